// ===== hw/rtl/prsch_pkg.sv =====
// Shared constants, types and helpers for the process scheduler.
`default_nettype none

package prsch_pkg;

  // Storage sizes
  localparam int READY_DEPTH   = 16;
  localparam int BACKLOG_DEPTH = 64;
  localparam int TIME_WIDTH    = 32;

  // Derived widths
  localparam int RIDX_W = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int RCNT_W = $clog2(READY_DEPTH + 1);
  localparam int BIDX_W = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
  localparam int BCNT_W = $clog2(BACKLOG_DEPTH + 1);

  // Field widths
  localparam int ID_W       = 16;
  localparam int DUR_W      = 16;
  localparam int EVT_W      = 32;
  localparam int ACT_W      = 2;
  localparam int QUANT_W    = 8;
  localparam int SLOTS_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS   = 2'd2;

  // Item kinds and policies
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_STEP   = 1'b1;
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_RR   = 1'b1;

  // Reset values of the configuration registers
  localparam logic [QUANT_W-1:0] QUANTUM_RST = 8'd1;
  localparam logic [SLOTS_W-1:0] SLOTS_RST   = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_START  = 2'd0,
    ACT_EXEC   = 2'd1,
    ACT_END    = 2'd2,
    ACT_REJECT = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic exec;     // process the latched item
    logic cfg_we;   // write a configuration register
  } prsch_cmd_t;

  typedef logic [RCNT_W-1:0] rcnt_t;

  // Usable ready table entries for a ready_slots setting
  function automatic rcnt_t room_of(input logic [SLOTS_W-1:0] slots);
    rcnt_t r;
    if (slots == '0) begin
      r = rcnt_t'(1);
    end else if (int'(slots) > READY_DEPTH) begin
      r = rcnt_t'(READY_DEPTH);
    end else begin
      r = rcnt_t'(slots);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/prsch_ctrl.sv =====
// Controller state machine: item acceptance and processing sequence.
`default_nettype none

module prsch_ctrl
  import prsch_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       cfg_valid,
  output logic            busy,
  output logic            cfg_ready,
  output prsch_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    busy        = 1'b0;
    cfg_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = ST_IDLE;
      end
    endcase
    cmd.cfg_we = cfg_valid && cfg_ready;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/prsch_datapath.sv =====
// Datapath: ready table, backlog memory, scheduler state and result registers.
`default_nettype none

module prsch_datapath
  import prsch_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire prsch_cmd_t            cmd,
  input  wire logic                  mode,
  input  wire logic [DUR_W-1:0]      duration,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       result_valid,
  output logic [EVT_W-1:0]           event_time,
  output logic [ID_W-1:0]            task_id,
  output logic [DUR_W-1:0]           task_duration,
  output logic [ACT_W-1:0]           action
);

  // Configuration
  logic               policy;
  logic [QUANT_W-1:0] quantum;
  logic [SLOTS_W-1:0] ready_slots;

  // Latched item
  logic             mode_q;
  logic [DUR_W-1:0] dur_q;

  // Ready table (register file, shifted in place)
  logic [ID_W-1:0]  rdy_id        [READY_DEPTH];
  logic [DUR_W-1:0] rdy_len       [READY_DEPTH];
  logic [DUR_W-1:0] rdy_left      [READY_DEPTH];
  logic [ID_W-1:0]  rdy_id_next   [READY_DEPTH];
  logic [DUR_W-1:0] rdy_len_next  [READY_DEPTH];
  logic [DUR_W-1:0] rdy_left_next [READY_DEPTH];

  // Backlog memory, circular
  logic [ID_W-1:0]  bl_id_mem  [BACKLOG_DEPTH];
  logic [DUR_W-1:0] bl_len_mem [BACKLOG_DEPTH];
  logic [ID_W-1:0]  bl_head_id;
  logic [DUR_W-1:0] bl_head_len;
  logic [BIDX_W-1:0] rd_ptr, rd_ptr_next;
  logic [BIDX_W-1:0] wr_ptr, wr_ptr_next;
  logic [BCNT_W-1:0] bl_count, bl_count_next;
  logic              bl_push;

  // Scheduler state
  logic [RCNT_W-1:0]     ready_count, ready_count_next;
  logic [RIDX_W-1:0]     current_slot, current_slot_next;
  logic [TIME_WIDTH-1:0] clock_count, clock_count_next;
  logic [QUANT_W-1:0]    slice_ticks, slice_ticks_next;
  logic                  in_slice, in_slice_next;
  logic [ID_W-1:0]       next_id, next_id_next;

  // Step working values
  rcnt_t              room;
  logic               bl_full;
  logic [RIDX_W-1:0]  s;
  logic [ID_W-1:0]    sel_id;
  logic [DUR_W-1:0]   sel_len;
  logic [DUR_W-1:0]   sel_left;
  logic [QUANT_W-1:0] q;
  logic [QUANT_W:0]   slice_sum;
  logic               retire;
  logic               emit;
  action_t            emit_act;
  logic [ID_W-1:0]    emit_id;
  logic [DUR_W-1:0]   emit_len;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POLICY_RR;
      quantum     <= QUANTUM_RST;
      ready_slots <= SLOTS_RST;
    end else if (cmd.cfg_we) begin
      unique case (cfg_index)
        CFG_POLICY:  policy      <= cfg_data[0];
        CFG_QUANTUM: quantum     <= cfg_data[QUANT_W-1:0];
        CFG_SLOTS:   ready_slots <= cfg_data[SLOTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the item for the processing cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      dur_q  <= duration;
    end
  end

  // Backlog memory: write the tail, read the head every cycle
  always_ff @(posedge clk) begin
    if (bl_push) begin
      bl_id_mem[wr_ptr]  <= next_id;
      bl_len_mem[wr_ptr] <= dur_q;
    end
    bl_head_id  <= bl_id_mem[rd_ptr];
    bl_head_len <= bl_len_mem[rd_ptr];
  end

  assign room    = room_of(ready_slots);
  assign bl_full = (bl_count == BCNT_W'(BACKLOG_DEPTH));
  assign q       = (quantum == '0) ? QUANT_W'(1) : quantum;
  assign s       = (RCNT_W'(current_slot) >= ready_count) ? '0 : current_slot;
  assign sel_id   = rdy_id[s];
  assign sel_len  = rdy_len[s];
  assign sel_left = rdy_left[s];
  assign slice_sum = {1'b0, slice_ticks} + 1'b1;

  // Work out one item
  always_comb begin
    rdy_id_next       = rdy_id;
    rdy_len_next      = rdy_len;
    rdy_left_next     = rdy_left;
    rd_ptr_next       = rd_ptr;
    wr_ptr_next       = wr_ptr;
    bl_count_next     = bl_count;
    bl_push           = 1'b0;
    ready_count_next  = ready_count;
    current_slot_next = current_slot;
    clock_count_next  = clock_count;
    slice_ticks_next  = slice_ticks;
    in_slice_next     = in_slice;
    next_id_next      = next_id;
    retire            = 1'b0;
    emit              = 1'b0;
    emit_act          = ACT_START;
    emit_id           = sel_id;
    emit_len          = sel_len;

    if (cmd.exec) begin
      if (mode_q == MODE_LOAD) begin
        if (dur_q == '0 || bl_full) begin
          emit     = 1'b1;
          emit_act = ACT_REJECT;
          emit_id  = next_id;
          emit_len = dur_q;
        end else begin
          if (ready_count < room && bl_count == '0) begin
            rdy_id_next[ready_count[RIDX_W-1:0]]   = next_id;
            rdy_len_next[ready_count[RIDX_W-1:0]]  = dur_q;
            rdy_left_next[ready_count[RIDX_W-1:0]] = dur_q;
            ready_count_next = ready_count + 1'b1;
          end else begin
            bl_push       = 1'b1;
            bl_count_next = bl_count + 1'b1;
            wr_ptr_next   = (wr_ptr == BIDX_W'(BACKLOG_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
          end
          next_id_next = (next_id == '1) ? ID_W'(1) : next_id + 1'b1;
        end
      end else if (ready_count != '0) begin
        current_slot_next = s;
        emit              = 1'b1;
        if (policy == POLICY_FIFO) begin
          if (!in_slice) begin
            if (sel_left == '0) begin
              emit_act = ACT_END;
              retire   = 1'b1;
            end else begin
              in_slice_next    = 1'b1;
              slice_ticks_next = '0;
              emit_act         = ACT_START;
            end
          end else begin
            clock_count_next = clock_count + 1'b1;
            if (sel_left <= DUR_W'(1)) begin
              emit_act = ACT_END;
              retire   = 1'b1;
            end else begin
              rdy_left_next[s] = sel_left - 1'b1;
              emit_act         = ACT_EXEC;
            end
          end
        end else begin
          if (sel_left == '0) begin
            emit_act = ACT_END;
            retire   = 1'b1;
          end else if (!in_slice) begin
            in_slice_next    = 1'b1;
            slice_ticks_next = '0;
            emit_act         = ACT_START;
          end else begin
            rdy_left_next[s] = sel_left - 1'b1;
            clock_count_next = clock_count + 1'b1;
            emit_act         = ACT_EXEC;
            // end of turn: advance to the following slot
            if (slice_sum >= {1'b0, q}) begin
              in_slice_next     = 1'b0;
              slice_ticks_next  = '0;
              current_slot_next = s + 1'b1;
            end else begin
              slice_ticks_next = slice_sum[QUANT_W-1:0];
            end
          end
        end
      end
    end

    // Drop the served slot, shift later slots down, refill from the backlog
    if (retire) begin
      for (int i = 0; i < READY_DEPTH; i++) begin
        if (i >= int'(s) && i + 1 < int'(ready_count)) begin
          rdy_id_next[i]   = rdy_id[(i + 1) % READY_DEPTH];
          rdy_len_next[i]  = rdy_len[(i + 1) % READY_DEPTH];
          rdy_left_next[i] = rdy_left[(i + 1) % READY_DEPTH];
        end
        if (bl_count != '0 && i + 1 == int'(ready_count)) begin
          rdy_id_next[i]   = bl_head_id;
          rdy_len_next[i]  = bl_head_len;
          rdy_left_next[i] = bl_head_len;
        end
      end
      if (bl_count != '0) begin
        bl_count_next = bl_count - 1'b1;
        rd_ptr_next   = (rd_ptr == BIDX_W'(BACKLOG_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end else begin
        ready_count_next = ready_count - 1'b1;
      end
      in_slice_next = 1'b0;
    end
  end

  // Ready table update
  always_ff @(posedge clk) begin
    rdy_id   <= rdy_id_next;
    rdy_len  <= rdy_len_next;
    rdy_left <= rdy_left_next;
  end

  // Scheduler state update
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      bl_count     <= '0;
      ready_count  <= '0;
      current_slot <= '0;
      clock_count  <= '0;
      slice_ticks  <= '0;
      in_slice     <= 1'b0;
      next_id      <= ID_W'(1);
    end else begin
      rd_ptr       <= rd_ptr_next;
      wr_ptr       <= wr_ptr_next;
      bl_count     <= bl_count_next;
      ready_count  <= ready_count_next;
      current_slot <= current_slot_next;
      clock_count  <= clock_count_next;
      slice_ticks  <= slice_ticks_next;
      in_slice     <= in_slice_next;
      next_id      <= next_id_next;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      event_time    <= EVT_W'(clock_count_next);
      task_id       <= emit_id;
      task_duration <= emit_len;
      action        <= emit_act;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/process_scheduler_rr_fifo.sv =====
// Top level of the process scheduler: controller and datapath.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   item     | start / busy           | mode, duration
//   result   | result_valid (strobe)  | event_time, task_id, task_duration, action
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An item is accepted at the latching edge and then worked out in the processing state:
// the whole step is worked out against the ready table and the registered head
// of the backlog memory. Its result, if any, is strobed in the cycle that follows.
// Reset is synchronous; the ready table and backlog memory need no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module process_scheduler_rr_fifo
  import prsch_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  mode,
  input  wire logic [DUR_W-1:0]      duration,
  output logic                       result_valid,
  output logic [EVT_W-1:0]           event_time,
  output logic [ID_W-1:0]            task_id,
  output logic [DUR_W-1:0]           task_duration,
  output logic [ACT_W-1:0]           action,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  prsch_cmd_t cmd;

  prsch_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  prsch_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .mode          (mode),
    .duration      (duration),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .event_time    (event_time),
    .task_id       (task_id),
    .task_duration (task_duration),
    .action        (action)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/prsch_checker.sv =====
// Port-level checks for the process scheduler, bound to the top level.
`default_nettype none

module prsch_checker
  import prsch_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  mode,
  input wire logic                  result_valid,
  input wire logic [ACT_W-1:0]      action,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready
);

  // An accepted transaction occupies exactly one processing cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted item");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // A result is preceded by busy and, before that, by an accepted item
  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy) && $past(start && !busy, 2))
    else $error("result strobe without a matching item");

  // Rejections answer loads only
  a_reject_on_load: assert property (@(posedge clk) disable iff (rst)
    result_valid && action == ACT_REJECT |-> $past(mode, 2) == MODE_LOAD)
    else $error("reject reported for a step item");

  // No configuration write lands during processing
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !busy)
    else $error("configuration written while processing");

endmodule

bind process_scheduler_rr_fifo prsch_checker u_prsch_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .mode         (mode),
  .result_valid (result_valid),
  .action       (action),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the process scheduler: directed and random items checked against a model.
`timescale 1ns / 1ps

module testbench;
  import prsch_pkg::*;

  // Index with no register behind it; writes to it change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int MAX_SHOWN = 40;

  typedef struct packed {
    logic [EVT_W-1:0] t;
    logic [ID_W-1:0]  id;
    logic [DUR_W-1:0] len;
    action_t          act;
  } sched_event_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  logic                  mode      = MODE_LOAD;
  logic [DUR_W-1:0]      duration  = '0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  busy;
  logic                  result_valid;
  logic [EVT_W-1:0]      event_time;
  logic [ID_W-1:0]       task_id;
  logic [DUR_W-1:0]      task_duration;
  logic [ACT_W-1:0]      action;
  logic                  cfg_ready;

  process_scheduler_rr_fifo dut (.*);

  always #1 clk = ~clk;

  // Scheduler state as seen by the checker
  logic               pol;
  logic [QUANT_W-1:0] quant;
  logic [SLOTS_W-1:0] slots;
  logic [ID_W-1:0]    tbl_id   [READY_DEPTH];
  logic [DUR_W-1:0]   tbl_len  [READY_DEPTH];
  logic [DUR_W-1:0]   tbl_left [READY_DEPTH];
  logic [ID_W-1:0]    bl_id    [BACKLOG_DEPTH];
  logic [DUR_W-1:0]   bl_len   [BACKLOG_DEPTH];
  int                 tbl_cnt;
  int                 bl_cnt;
  int                 cur_slot;
  int                 turn_ticks;
  logic               turn_open;
  logic [EVT_W-1:0]   sched_clock;
  logic [ID_W-1:0]    id_next;

  sched_event_t pending_events[$];
  sched_event_t want;
  int           err_count = 0;
  int           idle_pct  = 0;

  task automatic report_mismatch(input string what);
    if (err_count < MAX_SHOWN) $display("mismatch at %0t: %s", $time, what);
    err_count++;
  endtask

  function automatic void scheduler_reset();
    pol         = POLICY_RR;
    quant       = QUANTUM_RST;
    slots       = SLOTS_RST;
    tbl_cnt     = 0;
    bl_cnt      = 0;
    cur_slot    = 0;
    turn_ticks  = 0;
    turn_open   = 1'b0;
    sched_clock = '0;
    id_next     = ID_W'(1);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_POLICY:  pol   = val[0];
      CFG_QUANTUM: quant = val[QUANT_W-1:0];
      CFG_SLOTS:   slots = val[SLOTS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic sched_event_t make_event(input logic [ID_W-1:0] id,
                                              input logic [DUR_W-1:0] len,
                                              input action_t act);
    return '{sched_clock, id, len, act};
  endfunction

  // Drop slot s, close up the table and pull the backlog head onto its end
  function automatic void remove_task(input int s);
    int i;
    if (tbl_cnt == 0 || s >= tbl_cnt) return;
    for (i = s; i + 1 < tbl_cnt; i++) begin
      tbl_id[i]   = tbl_id[i + 1];
      tbl_len[i]  = tbl_len[i + 1];
      tbl_left[i] = tbl_left[i + 1];
    end
    if (bl_cnt > 0) begin
      tbl_id[tbl_cnt - 1]   = bl_id[0];
      tbl_len[tbl_cnt - 1]  = bl_len[0];
      tbl_left[tbl_cnt - 1] = bl_len[0];
      for (i = 0; i + 1 < bl_cnt; i++) begin
        bl_id[i]  = bl_id[i + 1];
        bl_len[i] = bl_len[i + 1];
      end
      bl_cnt--;
    end else begin
      tbl_cnt--;
    end
    turn_open = 1'b0;
  endfunction

  // Advance the scheduler by one item; returns 1 when the item yields an event
  function automatic bit scheduler_event(input logic m, input logic [DUR_W-1:0] d,
                                         output sched_event_t ev);
    int               room;
    int               s;
    int               q;
    logic [ID_W-1:0]  id;
    logic [DUR_W-1:0] len;
    ev = '0;
    if (m == MODE_LOAD) begin
      room = (slots == '0) ? 1 : ((int'(slots) > READY_DEPTH) ? READY_DEPTH : int'(slots));
      // a full backlog refuses even when the table has room
      if (d == '0 || bl_cnt >= BACKLOG_DEPTH) begin
        ev = make_event(id_next, d, ACT_REJECT);
        return 1'b1;
      end
      if (tbl_cnt < room && bl_cnt == 0) begin
        tbl_id[tbl_cnt]   = id_next;
        tbl_len[tbl_cnt]  = d;
        tbl_left[tbl_cnt] = d;
        tbl_cnt++;
      end else begin
        bl_id[bl_cnt]  = id_next;
        bl_len[bl_cnt] = d;
        bl_cnt++;
      end
      id_next = (id_next == '1) ? ID_W'(1) : id_next + ID_W'(1);
      return 1'b0;
    end

    if (tbl_cnt == 0) return 1'b0;
    if (cur_slot >= tbl_cnt) cur_slot = 0;
    s   = cur_slot;
    id  = tbl_id[s];
    len = tbl_len[s];

    if (pol == POLICY_FIFO) begin
      if (!turn_open) begin
        if (tbl_left[s] == '0) begin
          ev = make_event(id, len, ACT_END);
          remove_task(s);
        end else begin
          turn_open  = 1'b1;
          turn_ticks = 0;
          ev = make_event(id, len, ACT_START);
        end
      end else begin
        sched_clock++;
        if (tbl_left[s] <= 1) begin
          tbl_left[s] = '0;
          ev = make_event(id, len, ACT_END);
          remove_task(s);
        end else begin
          tbl_left[s]--;
          ev = make_event(id, len, ACT_EXEC);
        end
      end
      return 1'b1;
    end

    // Round robin: a task out of time ends on its turn without a tick
    q = (quant == '0) ? 1 : int'(quant);
    if (tbl_left[s] == '0) begin
      ev = make_event(id, len, ACT_END);
      remove_task(s);
    end else if (!turn_open) begin
      turn_open  = 1'b1;
      turn_ticks = 0;
      ev = make_event(id, len, ACT_START);
    end else begin
      tbl_left[s]--;
      sched_clock++;
      turn_ticks++;
      ev = make_event(id, len, ACT_EXEC);
      if (turn_ticks >= q) begin
        turn_open  = 1'b0;
        turn_ticks = 0;
        cur_slot++;
      end
    end
    return 1'b1;
  endfunction

  // Check each strobed result against the oldest expected event
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result t=%0d id=%0d dur=%0d act=%0d",
                                  event_time, task_id, task_duration, action));
      end else begin
        want = pending_events.pop_front();
        if (event_time !== want.t || task_id !== want.id ||
            task_duration !== want.len || action !== want.act) begin
          report_mismatch($sformatf("t/id/dur/act got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d",
                                    event_time, task_id, task_duration, action,
                                    want.t, want.id, want.len, want.act));
        end
      end
    end
  end

  // Send one transaction after a random idle gap; predict its event on acceptance
  task automatic send_item(input logic m, input logic [DUR_W-1:0] d);
    sched_event_t ev;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start    <= 1'b0;
      mode     <= 1'($urandom_range(1));
      duration <= DUR_W'($urandom);
    end
    @(negedge clk);
    start    <= 1'b1;
    mode     <= m;
    duration <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (scheduler_event(m, d, ev)) pending_events.push_back(ev);
  endtask

  task automatic hold_sender();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic wait_results();
    hold_sender();
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // Registers change only with the block idle: drain, then allow for a silent item
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_results();
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic step_until_empty();
    while (tbl_cnt > 0) send_item(MODE_STEP, DUR_W'($urandom));
  endtask

  task automatic test_empty_and_reject();
    send_item(MODE_STEP, '1);
    send_item(MODE_LOAD, '0);
    send_item(MODE_STEP, '0);
  endtask

  task automatic test_round_robin();
    send_item(MODE_LOAD, DUR_W'(1));
    send_item(MODE_LOAD, DUR_W'(3));
    send_item(MODE_LOAD, DUR_W'(2));
    step_until_empty();
    // lengthen the quantum, then shorten it part way through a turn
    write_reg(CFG_QUANTUM, 8'd3);
    send_item(MODE_LOAD, DUR_W'(6));
    send_item(MODE_LOAD, DUR_W'(2));
    repeat (3) send_item(MODE_STEP, '0);
    write_reg(CFG_QUANTUM, 8'd1);
    step_until_empty();
  endtask

  task automatic test_fifo_and_switch();
    write_reg(CFG_POLICY, {7'd0, POLICY_FIFO});
    send_item(MODE_LOAD, DUR_W'(3));
    send_item(MODE_LOAD, DUR_W'(1));
    step_until_empty();
    // task out of time while its turn is still open: ends on the next tick
    write_reg(CFG_POLICY, {7'd0, POLICY_RR});
    write_reg(CFG_QUANTUM, 8'd8);
    send_item(MODE_LOAD, DUR_W'(2));
    repeat (3) send_item(MODE_STEP, '0);
    write_reg(CFG_POLICY, {7'd0, POLICY_FIFO});
    send_item(MODE_STEP, '0);
    // task out of time with its turn closed: ends at once
    write_reg(CFG_POLICY, {7'd0, POLICY_RR});
    write_reg(CFG_QUANTUM, 8'd2);
    send_item(MODE_LOAD, DUR_W'(2));
    repeat (3) send_item(MODE_STEP, '0);
    write_reg(CFG_POLICY, {7'd0, POLICY_FIFO});
    send_item(MODE_STEP, '0);
    // switch with the pointer past the first slot
    write_reg(CFG_POLICY, {7'd0, POLICY_RR});
    write_reg(CFG_QUANTUM, 8'd1);
    send_item(MODE_LOAD, DUR_W'(4));
    send_item(MODE_LOAD, DUR_W'(4));
    repeat (2) send_item(MODE_STEP, '0);
    write_reg(CFG_POLICY, {7'd0, POLICY_FIFO});
    step_until_empty();
    write_reg(CFG_POLICY, {7'd0, POLICY_RR});
  endtask

  task automatic test_ready_slots();
    idle_pct = 38;
    write_reg(CFG_SLOTS, 8'd1);
    repeat (3) send_item(MODE_LOAD, DUR_W'(2));
    // table has room again but the backlog still holds tasks
    write_reg(CFG_SLOTS, 8'd3);
    send_item(MODE_LOAD, DUR_W'(1));
    step_until_empty();
    write_reg(CFG_SLOTS, 8'd0);
    send_item(MODE_LOAD, DUR_W'(1));
    send_item(MODE_LOAD, DUR_W'(1));
    step_until_empty();
    // out of range clamps to the full table; lowering keeps what is there
    write_reg(CFG_SLOTS, 8'hFF);
    repeat (3) send_item(MODE_LOAD, DUR_W'(2));
    write_reg(CFG_SLOTS, 8'd2);
    send_item(MODE_LOAD, DUR_W'(1));
    step_until_empty();
    write_reg(CFG_SPARE, 8'hA5);
    write_reg(CFG_SLOTS, 8'd16);
    idle_pct = 0;
  endtask

  task automatic test_backlog_full();
    idle_pct = 0;
    write_reg(CFG_POLICY, {7'd0, POLICY_FIFO});
    while (bl_cnt < BACKLOG_DEPTH) send_item(MODE_LOAD, DUR_W'($urandom_range(2, 1)));
    send_item(MODE_LOAD, '1);
    send_item(MODE_LOAD, '0);
    send_item(MODE_LOAD, 16'hAAAA);
    send_item(MODE_LOAD, 16'h5555);
    repeat (4) send_item(MODE_LOAD, DUR_W'($urandom));
    while (bl_cnt >= BACKLOG_DEPTH) send_item(MODE_STEP, DUR_W'($urandom));
    send_item(MODE_LOAD, DUR_W'(2));
    send_item(MODE_LOAD, DUR_W'(5));
    step_until_empty();
  endtask

  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] quant_pick [8];
    logic [CFG_DATA_W-1:0] slot_pick  [8];
    logic                  pol_pick   [8];
    int                    idle_set   [4];
    int                    p;
    int                    i;
    int                    r;
    logic [DUR_W-1:0]      d;
    quant_pick = '{8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(255, 1)), 8'd2,
                   8'($urandom_range(32, 4)), 8'd1};
    slot_pick  = '{8'd16, 8'd1, 8'd0, 8'd4, 8'hFF, 8'($urandom_range(16, 1)), 8'd2, 8'd16};
    pol_pick   = '{POLICY_RR, POLICY_FIFO, POLICY_RR, POLICY_RR, POLICY_FIFO, POLICY_RR,
                   POLICY_FIFO, POLICY_RR};
    // the receiver cannot stall, so its phase runs flat out
    idle_set   = '{0, 61, 0, 38};
    for (p = 0; p < 8; p++) begin
      idle_pct = idle_set[p % 4];
      write_reg(CFG_POLICY, {7'($urandom), pol_pick[p]});
      write_reg(CFG_QUANTUM, quant_pick[p]);
      write_reg(CFG_SLOTS, slot_pick[p]);
      for (i = 0; i < 50; i++) begin
        if ($urandom_range(39) == 0) wait_results();
        if ($urandom_range(99) < 15) begin
          r = $urandom_range(99);
          if (r < 4) d = '0;
          else if (r < 14) d = DUR_W'($urandom_range(40, 9));
          else d = DUR_W'($urandom_range(8, 1));
          send_item(MODE_LOAD, d);
        end else begin
          send_item(MODE_STEP, DUR_W'($urandom));
        end
      end
    end
    idle_pct = 0;
  endtask

  // Longest tasks: run a few turns under both policies and leave them loaded
  task automatic test_long_task();
    step_until_empty();
    write_reg(CFG_POLICY, {7'd0, POLICY_RR});
    write_reg(CFG_QUANTUM, 8'd4);
    send_item(MODE_LOAD, '1);
    send_item(MODE_LOAD, 16'h8000);
    send_item(MODE_LOAD, DUR_W'(1));
    repeat (14) send_item(MODE_STEP, '1);
    write_reg(CFG_POLICY, {7'd0, POLICY_FIFO});
    repeat (6) send_item(MODE_STEP, '0);
  endtask

  initial begin
    int waited;
    scheduler_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_reject();
    test_round_robin();
    test_fifo_and_switch();
    test_ready_slots();
    test_backlog_full();
    test_random_traffic();
    test_long_task();

    // drain, then allow for the pipeline before the final verdict
    hold_sender();
    waited = 0;
    while (pending_events.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d expected events never arrived", pending_events.size()));
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== process_scheduler_rr_fifo.f =====
hw/rtl/prsch_pkg.sv
hw/rtl/prsch_ctrl.sv
hw/rtl/prsch_datapath.sv
hw/rtl/process_scheduler_rr_fifo.sv
hw/rtl/prsch_checker.sv
test/testbench.sv
